// File: rtl/wttp_pkg.sv
`default_nettype none
package wttp_pkg;

    // register indexes on the configuration port
    localparam logic [1:0] REG_LEVEL_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_WINDOW_LENGTH   = 2'd1;
    localparam logic [1:0] REG_MIN_COUNT       = 2'd2;

    localparam int THRESH_W = 16;
    localparam int WLEN_W   = 11;
    localparam int MCNT_W   = 11;
    localparam int SAMPLE_W = 16;

    localparam logic signed [THRESH_W-1:0] THRESH_RST = 16'sd2458;
    localparam logic [WLEN_W-1:0]          WLEN_RST   = 11'd40;
    localparam logic [MCNT_W-1:0]          MCNT_RST   = 11'd3;

    typedef struct packed {
        logic signed [THRESH_W-1:0] level_threshold;
        logic [WLEN_W-1:0]          window_length;
        logic [MCNT_W-1:0]          min_count;
    } t_cfg;

endpackage
`default_nettype wire

// File: rtl/wttp_cfg.sv
`default_nettype none
module wttp_cfg
    import wttp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output t_cfg             o_cfg
);

    t_cfg       r_cfg;
    t_cfg       n_cfg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel & penable & pwrite & pready;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            unique case (reg_idx)
                REG_LEVEL_THRESHOLD: n_cfg.level_threshold = pwdata[THRESH_W-1:0];
                REG_WINDOW_LENGTH:   n_cfg.window_length   = pwdata[WLEN_W-1:0];
                REG_MIN_COUNT:       n_cfg.min_count       = pwdata[MCNT_W-1:0];
                default:             n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.level_threshold <= THRESH_RST;
            r_cfg.window_length   <= WLEN_RST;
            r_cfg.min_count       <= MCNT_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_LEVEL_THRESHOLD: prdata = 32'(r_cfg.level_threshold);
            REG_WINDOW_LENGTH:   prdata = {{(32-WLEN_W){1'b0}}, r_cfg.window_length};
            REG_MIN_COUNT:       prdata = {{(32-MCNT_W){1'b0}}, r_cfg.min_count};
            default:             prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

// File: rtl/windowed_threshold_trim_point.sv
// A sample beat passes the input register, then its result beat is registered in the result register.
// Throughput: one sample per cycle while the result side is not stalled; the
// per-sample compare and counter update is one register-to-register step.
// Reset (i_rst_n low, synchronous): read state cleared, beats dropped,
// configuration back to threshold 2458, window 40, minimum count 3.
`default_nettype none
module windowed_threshold_trim_point
    import wttp_pkg::*;
#(
    parameter int SKIP_SAMPLES = 10,
    parameter int MAX_WINDOW   = 1024,
    parameter int LENGTH_BITS  = 24
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    // sample channel
    input  wire logic                    i_in_valid,
    output logic                         o_in_stall,
    input  wire logic signed [SAMPLE_W-1:0] i_sample_value,
    input  wire logic [LENGTH_BITS-1:0]  i_read_length,
    input  wire logic                    i_last_sample,
    // result channel
    output logic                         o_out_valid,
    input  wire logic                    i_out_stall,
    output logic [LENGTH_BITS-1:0]       o_trim_position,
    // configuration
    input  wire logic                    psel,
    input  wire logic                    penable,
    input  wire logic                    pwrite,
    input  wire logic [3:0]              paddr,
    input  wire logic [31:0]             pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    // counter widths: fill and count never hold a full window, only its
    // next value does, so the compare width covers MAX_WINDOW itself
    localparam int WL_W   = $clog2(MAX_WINDOW + 1);
    localparam int FILL_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CW     = (WL_W > WLEN_W) ? WL_W : WLEN_W;

    localparam logic [CW-1:0]          MAXW     = CW'(MAX_WINDOW);
    localparam logic [LENGTH_BITS-1:0] SKIP     = LENGTH_BITS'(SKIP_SAMPLES);
    localparam logic [LENGTH_BITS-1:0] IDX_SAT  = {LENGTH_BITS{1'b1}};

    t_cfg cfg;

    wttp_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // ---------------------------------------------------------------
    // Input register: holds one sample beat until the datapath takes it.
    // ---------------------------------------------------------------
    logic                       r_in_valid;
    logic signed [SAMPLE_W-1:0] r_sample;
    logic [LENGTH_BITS-1:0]     r_len;
    logic                       r_last;

    // result register
    logic                       r_out_valid;
    logic [LENGTH_BITS-1:0]     r_out_pos;

    // per-read state
    logic [LENGTH_BITS-1:0]     r_index;
    logic [FILL_W-1:0]          r_fill;
    logic [FILL_W-1:0]          r_count;
    logic                       r_peak;
    logic                       r_done;

    logic                       out_free;
    logic                       fire;

    // the datapath step runs whenever a sample beat is held and the result slot can take a beat
    assign out_free   = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_sample <= i_sample_value;
            r_len    <= i_read_length;
            r_last   <= i_last_sample;
        end
    end

    // ---------------------------------------------------------------
    // Datapath: compare, window counters, end-of-search decision.
    // ---------------------------------------------------------------
    logic [CW-1:0]          wl_raw;
    logic [CW-1:0]          wl;
    logic                   above;
    logic                   active;
    logic [CW-1:0]          fill_inc;
    logic [CW-1:0]          count_inc;
    logic                   win_full;
    logic [LENGTH_BITS:0]   win_end;
    logic [LENGTH_BITS+1:0] end_plus_skip;
    logic                   win_in_read;
    logic                   peak_hit;
    logic                   win_result;
    logic                   last_result;
    logic [LENGTH_BITS-1:0] win_pos;

    logic [LENGTH_BITS-1:0] n_index;
    logic [FILL_W-1:0]      n_fill;
    logic [FILL_W-1:0]      n_count;
    logic                   n_peak;
    logic                   n_done;

    always_comb begin
        // window length: zero acts as one, oversize clamps to MAX_WINDOW
        wl_raw = CW'(cfg.window_length);
        if (wl_raw == '0) begin
            wl = CW'(1);
        end else if (wl_raw > MAXW) begin
            wl = MAXW;
        end else begin
            wl = wl_raw;
        end

        above     = r_sample > cfg.level_threshold;
        active    = !r_done && (r_index >= SKIP);
        fill_inc  = CW'(r_fill) + CW'(1);
        count_inc = CW'(r_count) + CW'(above);
        win_full  = active && (fill_inc >= wl);

        win_end       = {1'b0, r_index} + (LENGTH_BITS+1)'(1);
        end_plus_skip = {1'b0, win_end} + (LENGTH_BITS+2)'(SKIP_SAMPLES);
        win_in_read   = win_end <= {1'b0, r_len};
        peak_hit      = win_full && win_in_read
                        && ((count_inc > CW'(cfg.min_count)) || r_peak);
        win_result    = peak_hit && !above;

        // end too close to the read end falls back to the skip length
        win_pos = (end_plus_skip >= {2'b00, r_len}) ? SKIP
                                                     : win_end[LENGTH_BITS-1:0];

        // read over without a qualifying window
        last_result = r_last && !r_done && !win_result;

        // next state
        n_index = (r_index != IDX_SAT) ? r_index + LENGTH_BITS'(1) : r_index;
        n_fill  = r_fill;
        n_count = r_count;
        n_peak  = r_peak || peak_hit;
        n_done  = r_done || win_result;
        if (active) begin
            if (win_full) begin
                n_fill  = '0;
                n_count = '0;
            end else begin
                n_fill  = fill_inc[FILL_W-1:0];
                n_count = count_inc[FILL_W-1:0];
            end
        end
        if (r_last) begin
            n_index = '0;
            n_fill  = '0;
            n_count = '0;
            n_peak  = 1'b0;
            n_done  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index <= '0;
            r_fill  <= '0;
            r_count <= '0;
            r_peak  <= 1'b0;
            r_done  <= 1'b0;
        end else if (fire) begin
            r_index <= n_index;
            r_fill  <= n_fill;
            r_count <= n_count;
            r_peak  <= n_peak;
            r_done  <= n_done;
        end
    end

    // ---------------------------------------------------------------
    // Result register: at most one beat per read.
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= fire && (win_result || last_result);
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && (win_result || last_result)) begin
            r_out_pos <= win_result ? win_pos : SKIP;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_trim_position = r_out_pos;

endmodule
`default_nettype wire
